// ----- hw/rtl/shdl_pkg.sv -----
// ============================================================================
// shdl_pkg: shared types and constants for the sensor history logger
// ----------------------------------------------------------------------------
// Field widths, stream packing layout, result action codes and register
// indexes with their reset values.
// ============================================================================
package shdl_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 24;
    localparam int COUNT_W  = 7;
    localparam int ACTION_W = 2;
    localparam int DIFF_W   = 24;
    // Threshold grows to ignored_diff times an age rank of at most 127.
    localparam int THR_W    = DIFF_W + COUNT_W;

    // Stream beat widths, padded to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int M_USED_W  = ACTION_W + COUNT_W + TIME_W + VALUE_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_KEPT       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DELAY      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPARED_COUNT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IGNORED_DIFF   = 2'd3;

    localparam logic [COUNT_W-1:0] RST_MAX_KEPT       = 7'd64;
    localparam logic [TIME_W-1:0]  RST_MIN_DELAY      = 32'd60000;
    localparam logic [COUNT_W-1:0] RST_COMPARED_COUNT = 7'd3;
    localparam logic [DIFF_W-1:0]  RST_IGNORED_DIFF   = 24'd10;

    // Result action codes.
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP    = 2'd2;

    // One result beat, last field in the lowest bits.
    typedef struct packed {
        logic signed [VALUE_W-1:0] dropped_value;
        logic [TIME_W-1:0]         dropped_time;
        logic [COUNT_W-1:0]        stored_count;
        logic [ACTION_W-1:0]       action;
    } result_t;

endpackage

// ----- hw/rtl/sensor_history_deadband_logger.sv -----
// ============================================================================
// sensor_history_deadband_logger: bounded, deadbanded sample history
// ----------------------------------------------------------------------------
// Keeps a ring of timestamped samples in a one-read, one-write memory. Each sample
// either replaces the newest entry (when it is close in time and value to the
// newest entries) or is appended, dropping and reporting the oldest entry
// when the history is full.
// ============================================================================
// One input beat is taken at a time. With fewer than two entries stored, a
// sample goes straight to the write state. Otherwise the second-newest entry
// is read for the delay check, and unless the delay limit forces an append or
// no entries are compared, up to min(compared_count, stored entries) stored
// values are checked one by one before a decision: the history memory has one
// read port and the single deadband comparator reads one entry per cycle.
// A finished result waits in the output register, and the next sample is
// taken meanwhile; it stalls only in its write state until that beat is taken.
module sensor_history_deadband_logger #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [shdl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [shdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Sample stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: sample_time[31:0], sample_value[55:32].
    input  logic [shdl_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: action[1:0], stored_count[8:2], dropped_time[40:9],
    // dropped_value[64:41], zero padding above.
    output logic [shdl_pkg::M_TDATA_W-1:0]    m_tdata
);
    import shdl_pkg::*;

    localparam int IW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUMW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
    localparam logic [SUMW-1:0] DEPTH_S   = SUMW'(HISTORY_DEPTH);
    localparam logic [IW-1:0]   LAST_SLOT = IW'(HISTORY_DEPTH - 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TIME  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    // Fold a sum below twice the depth back into the ring.
    function automatic logic [IW-1:0] wrap_slot(input logic [SUMW-1:0] s);
        logic [SUMW-1:0] r;
        r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return r[IW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [1:0]                state_reg, state_next;
    logic [IW-1:0]             oldest_reg, oldest_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic [COUNT_W-1:0]        max_kept_reg;
    logic [TIME_W-1:0]         min_delay_reg;
    logic [COUNT_W-1:0]        compared_reg;
    logic [DIFF_W-1:0]         ignored_reg;

    logic [TIME_W-1:0]         samp_time_reg, samp_time_next;
    logic signed [VALUE_W-1:0] samp_value_reg, samp_value_next;
    logic [IW-1:0]             ptr_reg, ptr_next;
    logic [COUNT_W-1:0]        idx_reg, idx_next;
    logic [THR_W-1:0]          thr_reg, thr_next;
    logic signed [THR_W+1:0]   neg_thr_reg, neg_thr_next;
    logic                      append_reg, append_next;
    result_t                   out_reg, out_next;

    // History memory, time and value read together.
    logic [TIME_W-1:0]         time_mem [HISTORY_DEPTH];
    logic signed [VALUE_W-1:0] value_mem [HISTORY_DEPTH];
    logic [TIME_W-1:0]         rd_time_reg;
    logic signed [VALUE_W-1:0] rd_value_reg;
    logic [IW-1:0]             rd_addr;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [SUMW-1:0]           oldest_s, count_s, kept_s, limit_s;
    logic [IW-1:0]             rank2_slot, ptr_inc, ptr_dec;
    logic [TIME_W-1:0]         elapsed;
    logic signed [THR_W+1:0]   diff_s, thr_s;
    logic                      deadband_hit;
    logic [COUNT_W-1:0]        idx_inc;
    logic [ACTION_W-1:0]       action_w;
    logic                      out_free;
    logic                      s_accept;

    assign oldest_s   = SUMW'(oldest_reg);
    assign count_s    = SUMW'(count_reg);
    assign kept_s     = SUMW'(max_kept_reg);
    assign rank2_slot = wrap_slot(oldest_s + count_s - SUMW'(2));
    assign ptr_inc    = wrap_slot(SUMW'(ptr_reg) + SUMW'(1));
    assign ptr_dec    = (ptr_reg == '0) ? LAST_SLOT : (ptr_reg - IW'(1));
    assign elapsed    = samp_time_reg - rd_time_reg;
    assign idx_inc    = idx_reg + COUNT_W'(1);

    // Effective entry limit: zero acts as one, clipped to the depth.
    always_comb begin
        if (max_kept_reg == '0) begin
            limit_s = SUMW'(1);
        end else if (kept_s > DEPTH_S) begin
            limit_s = DEPTH_S;
        end else begin
            limit_s = kept_s;
        end
    end

    // Deadband test: |sample - entry| >= thr, as two signed compares.
    assign diff_s = (THR_W + 2)'(samp_value_reg) - (THR_W + 2)'(rd_value_reg);
    assign thr_s  = $signed({2'b00, thr_reg});
    assign deadband_hit = (diff_s >= thr_s) || (diff_s <= neg_thr_reg);

    // Action chosen once the append decision is made.
    always_comb begin
        if (!append_reg) begin
            action_w = ACT_REPLACE;
        end else if (count_s < limit_s) begin
            action_w = ACT_APPEND;
        end else begin
            action_w = ACT_DROP;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        samp_time_next  = samp_time_reg;
        samp_value_next = samp_value_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        thr_next        = thr_reg;
        neg_thr_next    = neg_thr_reg;
        append_next     = append_reg;
        out_next        = out_reg;
        rd_addr         = oldest_reg;
        wr_en           = 1'b0;
        wr_addr         = wrap_slot(oldest_s + count_s);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    samp_time_next  = s_tdata[TIME_W-1:0];
                    samp_value_next = $signed(s_tdata[TIME_W+VALUE_W-1:TIME_W]);
                    if (count_reg < COUNT_W'(2)) begin
                        append_next = 1'b1;
                        state_next  = ST_WRITE;
                    end else begin
                        // Fetch the second-newest entry for the delay check.
                        rd_addr    = rank2_slot;
                        ptr_next   = rank2_slot;
                        state_next = ST_TIME;
                    end
                end
            end

            ST_TIME: begin
                if (elapsed >= min_delay_reg) begin
                    append_next = 1'b1;
                    state_next  = ST_WRITE;
                end else if (compared_reg == '0) begin
                    append_next = 1'b0;
                    state_next  = ST_WRITE;
                end else begin
                    // Start the value scan at the newest entry.
                    rd_addr      = ptr_inc;
                    ptr_next     = ptr_inc;
                    idx_next     = '0;
                    thr_next     = THR_W'(ignored_reg);
                    neg_thr_next = -(THR_W + 2)'(ignored_reg);
                    state_next   = ST_CMP;
                end
            end

            ST_CMP: begin
                if (deadband_hit) begin
                    append_next = 1'b1;
                    state_next  = ST_WRITE;
                end else if (idx_inc >= compared_reg || idx_inc >= count_reg) begin
                    append_next = 1'b0;
                    state_next  = ST_WRITE;
                end else begin
                    // Step to the next older entry; the threshold grows by rank.
                    rd_addr      = ptr_dec;
                    ptr_next     = ptr_dec;
                    idx_next     = idx_inc;
                    thr_next     = thr_reg + THR_W'(ignored_reg);
                    neg_thr_next = neg_thr_reg - (THR_W + 2)'(ignored_reg);
                end
            end

            ST_WRITE: begin
                // The oldest entry has been read; commit once the output is free.
                if (!append_reg) begin
                    wr_addr = wrap_slot(oldest_s + count_s - SUMW'(1));
                end
                if (out_free) begin
                    wr_en         = 1'b1;
                    m_tvalid_next = 1'b1;
                    out_next.action        = action_w;
                    out_next.dropped_time  = '0;
                    out_next.dropped_value = '0;
                    if (action_w == ACT_APPEND) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (action_w == ACT_DROP) begin
                        oldest_next            = wrap_slot(oldest_s + SUMW'(1));
                        out_next.dropped_time  = rd_time_reg;
                        out_next.dropped_value = rd_value_reg;
                    end
                    out_next.stored_count = count_next;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers and configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            max_kept_reg  <= RST_MAX_KEPT;
            min_delay_reg <= RST_MIN_DELAY;
            compared_reg  <= RST_COMPARED_COUNT;
            ignored_reg   <= RST_IGNORED_DIFF;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_MAX_KEPT:       max_kept_reg  <= cfg_wdata[COUNT_W-1:0];
                    CFG_MIN_DELAY:      min_delay_reg <= cfg_wdata[TIME_W-1:0];
                    CFG_COMPARED_COUNT: compared_reg  <= cfg_wdata[COUNT_W-1:0];
                    CFG_IGNORED_DIFF:   ignored_reg   <= cfg_wdata[DIFF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        samp_time_reg  <= samp_time_next;
        samp_value_reg <= samp_value_next;
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        thr_reg        <= thr_next;
        neg_thr_reg    <= neg_thr_next;
        append_reg     <= append_next;
        out_reg        <= out_next;
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr]  <= samp_time_reg;
            value_mem[wr_addr] <= samp_value_reg;
        end
        rd_time_reg  <= time_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), out_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The stored count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SUMW'(count_reg) <= DEPTH_S)
        else $error("stored count exceeds history depth");

    // An accepted sample keeps the input closed for at least the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in progress");

    // A replacement only happens with at least two entries held.
    a_replace_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.action == ACT_REPLACE |-> out_reg.stored_count >= COUNT_W'(2))
        else $error("newest entry replaced with fewer than two entries");

    // Dropped fields are zero unless the oldest entry was dropped.
    a_drop_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.action != ACT_DROP |->
            out_reg.dropped_time == '0 && out_reg.dropped_value == '0)
        else $error("dropped fields set without a drop");

endmodule
